// ===== hw/rtl/gradient_step_norm_projection_top_macros.svh =====
// assertion macros for the projected gradient step block
`ifndef GRADIENT_STEP_NORM_PROJECTION_TOP_MACROS_SVH
`define GRADIENT_STEP_NORM_PROJECTION_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define GSNP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GSNP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gsnp_pkg.sv =====
// shared types and constants of the projected gradient step block
`timescale 1ns / 1ps

package gsnp_pkg;

  localparam int NCOORD     = 4;
  localparam int FRONT_LAT  = 5;
  localparam int ISQ_LAT    = 32;
  localparam int SCALE_LAT  = 35;
  localparam int TOTAL_LAT  = FRONT_LAT + ISQ_LAT + 2 * SCALE_LAT;

  typedef logic signed [31:0] coord_t;
  typedef coord_t [NCOORD-1:0] vec_t;

  localparam coord_t POS_MAX = 32'sh7FFF_FFFF;
  localparam coord_t NEG_MIN = 32'sh8000_0000;
  localparam logic [63:0] ONE_Q56 = 64'h0100_0000_0000_0000;
  localparam logic [31:0] UNIT_NUM = 32'h1000_0000;
  localparam logic [31:0] SHELL_RADIUS_RST = 32'd590558003;

  typedef enum logic [1:0] {
    MODE_BALL   = 2'd0,
    MODE_SHELL  = 2'd1,
    MODE_SPHERE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CFG_MODE            = 3'd0,
    CFG_STEP_MANTISSA   = 3'd1,
    CFG_STEP_SHIFT      = 3'd2,
    CFG_INNER_THRESHOLD = 3'd3,
    CFG_SHELL_RADIUS    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [19:0]        point_index;
    logic signed [31:0] x0;
    logic signed [31:0] x1;
    logic signed [31:0] x2;
    logic signed [31:0] x3;
    logic signed [47:0] g0;
    logic signed [47:0] g1;
    logic signed [47:0] g2;
    logic signed [47:0] g3;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic [19:0]        index_out;
    logic signed [31:0] y0;
    logic signed [31:0] y1;
    logic signed [31:0] y2;
    logic signed [31:0] y3;
    logic               last_out;
    logic               zero_norm;
    logic               saturated;
  } out_item_t;

endpackage

// ===== hw/rtl/gsnp_front.sv =====
// step, saturation, squaring and squared norm, five register stages
`timescale 1ns / 1ps

module gsnp_front import gsnp_pkg::*; #(
  parameter int DIM = 3
) (
  input  logic        clk,
  input  in_item_t    in_item,
  input  logic [31:0] step_mantissa,
  input  logic [5:0]  step_shift,
  output vec_t        y,
  output logic        sat,
  output logic [63:0] norm_sq
);

  coord_t             xa [NCOORD];
  logic signed [47:0] ga [NCOORD];
  coord_t             y_l [NCOORD];
  logic               sat_l [NCOORD];
  logic [63:0]        sq_l [NCOORD];
  logic [6:0]         shamt;

  vec_t        y5_r;
  logic        sat5_r;
  logic [63:0] n5_r;
  logic [65:0] sum;
  logic        sat_any;

  // unpack lanes
  assign xa[0] = in_item.x0;
  assign xa[1] = in_item.x1;
  assign xa[2] = in_item.x2;
  assign xa[3] = in_item.x3;
  assign ga[0] = in_item.g0;
  assign ga[1] = in_item.g1;
  assign ga[2] = in_item.g2;
  assign ga[3] = in_item.g3;

  assign shamt = 7'(step_shift) + 7'd28;

  for (genvar j = 0; j < NCOORD; j++) begin : g_lane
    if (j < DIM) begin : g_on
      logic [47:0]        gmag;
      coord_t             x1_r, x2_r, y3_r, y4_r;
      logic               neg1_r, neg2_r, sat3_r, sat4_r;
      logic [55:0]        pl_r, ph_r;
      logic [79:0]        prod_r;
      logic [79:0]        qm;
      logic signed [53:0] xe, qe, ysum;
      coord_t             yclip;
      logic               yclip_sat;
      logic [31:0]        amag;
      logic [63:0]        sq4_r;

      // gradient magnitude split into two partial products
      assign gmag = ga[j][47] ? 48'(-ga[j]) : 48'(ga[j]);

      always_ff @(posedge clk) begin
        x1_r   <= xa[j];
        neg1_r <= ga[j][47];
        pl_r   <= 56'(step_mantissa) * 56'(gmag[23:0]);
        ph_r   <= 56'(step_mantissa) * 56'(gmag[47:24]);
      end

      // full product
      always_ff @(posedge clk) begin
        x2_r   <= x1_r;
        neg2_r <= neg1_r;
        prod_r <= {ph_r, 24'd0} + 80'(pl_r);
      end

      // scale to Q28, subtract and clip
      always_comb begin
        qm        = prod_r >> shamt;
        xe        = 54'(x2_r);
        qe        = $signed({2'b00, qm[51:0]});
        ysum      = neg2_r ? xe + qe : xe - qe;
        yclip     = ysum[31:0];
        yclip_sat = 1'b0;
        if (ysum > 54'sd2147483647) begin
          yclip     = POS_MAX;
          yclip_sat = 1'b1;
        end else if (ysum < -54'sd2147483648) begin
          yclip     = NEG_MIN;
          yclip_sat = 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        y3_r   <= yclip;
        sat3_r <= yclip_sat;
      end

      // square of the clipped coordinate
      assign amag = y3_r[31] ? 32'(-y3_r) : 32'(y3_r);

      always_ff @(posedge clk) begin
        y4_r   <= y3_r;
        sat4_r <= sat3_r;
        sq4_r  <= 64'(amag) * 64'(amag);
      end

      assign y_l[j]   = y4_r;
      assign sat_l[j] = sat4_r;
      assign sq_l[j]  = sq4_r;
    end else begin : g_off
      assign y_l[j]   = '0;
      assign sat_l[j] = 1'b0;
      assign sq_l[j]  = '0;
    end
  end

  // squared norm with saturation
  always_comb begin
    sum     = '0;
    sat_any = 1'b0;
    for (int j = 0; j < NCOORD; j++) begin
      sum     = sum + 66'(sq_l[j]);
      sat_any = sat_any | sat_l[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NCOORD; j++) begin
      y5_r[j] <= y_l[j];
    end
    sat5_r <= sat_any;
    n5_r   <= (sum[65:64] != 2'b00) ? '1 : sum[63:0];
  end

  assign y       = y5_r;
  assign sat     = sat5_r;
  assign norm_sq = n5_r;

endmodule

// ===== hw/rtl/gsnp_isqrt.sv =====
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps

module gsnp_isqrt import gsnp_pkg::*; (
  input  logic        clk,
  input  logic [63:0] norm_sq,
  output logic [31:0] root,
  output logic [63:0] norm_out
);

  logic [63:0] rem_r [ISQ_LAT];
  logic [63:0] res_r [ISQ_LAT];
  logic [63:0] n_r   [ISQ_LAT];

  for (genvar k = 0; k < ISQ_LAT; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] rem_in, res_in, n_in, trial;

    if (k == 0) begin : g_first
      assign rem_in = norm_sq;
      assign res_in = '0;
      assign n_in   = norm_sq;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
      assign n_in   = n_r[k-1];
    end

    assign trial = res_in + BIT;

    // one restoring root step
    always_ff @(posedge clk) begin
      n_r[k] <= n_in;
      if (rem_in >= trial) begin
        rem_r[k] <= rem_in - trial;
        res_r[k] <= (res_in >> 1) + BIT;
      end else begin
        rem_r[k] <= rem_in;
        res_r[k] <= res_in >> 1;
      end
    end
  end

  assign root     = res_r[ISQ_LAT-1][31:0];
  assign norm_out = n_r[ISQ_LAT-1];

endmodule

// ===== hw/rtl/gsnp_scale.sv =====
// coordinate rescale by num/den with a pipelined divider and clipping
`timescale 1ns / 1ps

module gsnp_scale import gsnp_pkg::*; (
  input  logic        clk,
  input  coord_t      v,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [33:0] den,
  output coord_t      v_out,
  output logic        sat_out
);

  localparam int DIV_STEPS = 32;

  logic [31:0] vmag;
  logic [63:0] p0_r;
  coord_t      v0_r;
  logic        en0_r;
  logic [33:0] den0_r;

  logic [34:0] rem_r [DIV_STEPS+1];
  logic [31:0] low_r [DIV_STEPS+1];
  logic [31:0] q_r   [DIV_STEPS+1];
  coord_t      v_r   [DIV_STEPS+1];
  logic        en_r  [DIV_STEPS+1];
  logic [33:0] den_r [DIV_STEPS+1];
  logic        ovf_r [DIV_STEPS+1];
  logic        dz_r  [DIV_STEPS+1];

  coord_t      res;
  logic        res_sat;
  coord_t      vo_r;
  logic        so_r;
  logic [31:0] qf;

  // magnitude times numerator
  assign vmag = v[31] ? 32'(-v) : 32'(v);

  always_ff @(posedge clk) begin
    p0_r   <= 64'(vmag) * 64'(num);
    v0_r   <= v;
    en0_r  <= en;
    den0_r <= den;
  end

  // overflow check and divider setup
  always_ff @(posedge clk) begin
    rem_r[0] <= {3'b000, p0_r[63:32]};
    low_r[0] <= p0_r[31:0];
    q_r[0]   <= '0;
    v_r[0]   <= v0_r;
    en_r[0]  <= en0_r;
    den_r[0] <= den0_r;
    ovf_r[0] <= {2'b00, p0_r[63:32]} >= den0_r;
    dz_r[0]  <= den0_r == '0;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [34:0] trial;
    logic        ge;

    assign trial = {rem_r[k][33:0], low_r[k][31]};
    assign ge    = trial >= {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? trial - {1'b0, den_r[k]} : trial;
      low_r[k+1] <= {low_r[k][30:0], 1'b0};
      q_r[k+1]   <= {q_r[k][30:0], ge};
      v_r[k+1]   <= v_r[k];
      en_r[k+1]  <= en_r[k];
      den_r[k+1] <= den_r[k];
      ovf_r[k+1] <= ovf_r[k];
      dz_r[k+1]  <= dz_r[k];
    end
  end

  // sign, clip, zero on a zero divisor, and bypass when not enabled
  always_comb begin
    qf      = q_r[DIV_STEPS];
    res     = v_r[DIV_STEPS];
    res_sat = 1'b0;
    if (en_r[DIV_STEPS]) begin
      if (dz_r[DIV_STEPS]) begin
        res = '0;
      end else if (!v_r[DIV_STEPS][31]) begin
        if (ovf_r[DIV_STEPS] || qf > 32'h7FFF_FFFF) begin
          res     = POS_MAX;
          res_sat = 1'b1;
        end else begin
          res = $signed(qf);
        end
      end else begin
        if (ovf_r[DIV_STEPS] || qf > 32'h8000_0000) begin
          res     = NEG_MIN;
          res_sat = 1'b1;
        end else begin
          res = $signed(32'(-qf));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    vo_r <= res;
    so_r <= res_sat;
  end

  assign v_out   = vo_r;
  assign sat_out = so_r;

endmodule

// ===== hw/rtl/gradient_step_norm_projection_top.sv =====
// top level: projected gradient step onto unit ball, shell or sphere
// throughput: one item every cycle, set by the fully pipelined root and dividers
// the root takes 32 stages, each rescale 35 stages (32 of them for the divider)
// busy stays low; results cannot be held off
// reset: synchronous, clears valid bits and config (shell radius to 0.55)
`timescale 1ns / 1ps
`include "gradient_step_norm_projection_top_macros.svh"

module gradient_step_norm_projection_top import gsnp_pkg::*; #(
  parameter int DIM = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef struct packed {
    logic [19:0] index;
    logic        last;
  } ctrl_t;

  typedef struct packed {
    vec_t y;
    logic sat;
  } front_t;

  typedef struct packed {
    logic [31:0] r;
    logic        shell_en;
    logic        zn;
    logic        sat;
  } mid_t;

  typedef struct packed {
    logic zn;
    logic sat;
  } tail_t;

  logic [1:0]  mode_r;
  logic [31:0] step_mantissa_r;
  logic [5:0]  step_shift_r;
  logic [31:0] inner_threshold_r;
  logic [31:0] shell_radius_r;

  logic        in_accept;
  logic        vld_r  [TOTAL_LAT];
  ctrl_t       ctrl_r [TOTAL_LAT];

  vec_t        y_front;
  logic        sat_front;
  logic [63:0] n_front;
  front_t      fdl_r [ISQ_LAT];

  logic [31:0] root;
  logic [63:0] n_mid;
  logic        nz, inner_hit, unit_en, shell_en, zn;
  mid_t        mid_r [SCALE_LAT];
  tail_t       tail_r [SCALE_LAT];

  coord_t      ya [NCOORD];
  logic        sata [NCOORD];
  coord_t      yb [NCOORD];
  logic        satb [NCOORD];
  logic        sata_any, satb_any;

  logic        out_strobe_r;
  out_item_t   out_item_r;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r            <= MODE_BALL;
      step_mantissa_r   <= '0;
      step_shift_r      <= '0;
      inner_threshold_r <= '0;
      shell_radius_r    <= SHELL_RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:            mode_r            <= cfg_data[1:0];
        CFG_STEP_MANTISSA:   step_mantissa_r   <= cfg_data;
        CFG_STEP_SHIFT:      step_shift_r      <= cfg_data[5:0];
        CFG_INNER_THRESHOLD: inner_threshold_r <= cfg_data;
        CFG_SHELL_RADIUS:    shell_radius_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // item valid bits and side fields along the whole pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOTAL_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_accept;
      for (int i = 1; i < TOTAL_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    ctrl_r[0] <= '{index: in_item.point_index, last: in_item.last_in};
    for (int i = 1; i < TOTAL_LAT; i++) begin
      ctrl_r[i] <= ctrl_r[i-1];
    end
  end

  // step and squared norm
  gsnp_front #(.DIM(DIM)) u_front (
    .clk           (clk),
    .in_item       (in_item),
    .step_mantissa (step_mantissa_r),
    .step_shift    (step_shift_r),
    .y             (y_front),
    .sat           (sat_front),
    .norm_sq       (n_front)
  );

  // square root of the norm
  gsnp_isqrt u_isqrt (
    .clk      (clk),
    .norm_sq  (n_front),
    .root     (root),
    .norm_out (n_mid)
  );

  // coordinates wait for the root
  always_ff @(posedge clk) begin
    fdl_r[0] <= '{y: y_front, sat: sat_front};
    for (int i = 1; i < ISQ_LAT; i++) begin
      fdl_r[i] <= fdl_r[i-1];
    end
  end

  // projection decisions
  always_comb begin
    nz        = n_mid != '0;
    inner_hit = (mode_r == MODE_SHELL) && (n_mid < {6'd0, inner_threshold_r, 26'd0});
    unit_en   = (mode_r == MODE_SPHERE) ? nz : (n_mid > ONE_Q56);
    shell_en  = inner_hit && nz;
    zn        = !nz && ((mode_r == MODE_SPHERE) || inner_hit);
  end

  always_ff @(posedge clk) begin
    mid_r[0] <= '{r: root, shell_en: shell_en, zn: zn, sat: fdl_r[ISQ_LAT-1].sat};
    for (int i = 1; i < SCALE_LAT; i++) begin
      mid_r[i] <= mid_r[i-1];
    end
  end

  // unit rescale then shell rescale per coordinate
  for (genvar j = 0; j < NCOORD; j++) begin : g_lane
    if (j < DIM) begin : g_on
      gsnp_scale u_unit (
        .clk     (clk),
        .v       (fdl_r[ISQ_LAT-1].y[j]),
        .en      (unit_en),
        .num     (UNIT_NUM),
        .den     ({2'b00, root}),
        .v_out   (ya[j]),
        .sat_out (sata[j])
      );

      gsnp_scale u_shell (
        .clk     (clk),
        .v       (ya[j]),
        .en      (mid_r[SCALE_LAT-1].shell_en),
        .num     (shell_radius_r),
        .den     ({mid_r[SCALE_LAT-1].r, 2'b00}),
        .v_out   (yb[j]),
        .sat_out (satb[j])
      );
    end else begin : g_off
      assign ya[j]   = '0;
      assign sata[j] = 1'b0;
      assign yb[j]   = '0;
      assign satb[j] = 1'b0;
    end
  end

  always_comb begin
    sata_any = 1'b0;
    satb_any = 1'b0;
    for (int j = 0; j < NCOORD; j++) begin
      sata_any = sata_any | sata[j];
      satb_any = satb_any | satb[j];
    end
  end

  // flags wait for the shell rescale
  always_ff @(posedge clk) begin
    tail_r[0] <= '{zn: mid_r[SCALE_LAT-1].zn, sat: mid_r[SCALE_LAT-1].sat | sata_any};
    for (int i = 1; i < SCALE_LAT; i++) begin
      tail_r[i] <= tail_r[i-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_r[TOTAL_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_item_r.index_out <= ctrl_r[TOTAL_LAT-1].index;
    out_item_r.y0        <= yb[0];
    out_item_r.y1        <= yb[1];
    out_item_r.y2        <= yb[2];
    out_item_r.y3        <= yb[3];
    out_item_r.last_out  <= ctrl_r[TOTAL_LAT-1].last;
    out_item_r.zero_norm <= tail_r[SCALE_LAT-1].zn;
    out_item_r.saturated <= tail_r[SCALE_LAT-1].sat | satb_any;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // checks
  `GSNP_ASSERT_IMPL(a_zero_norm_zero_y, out_strobe && out_item.zero_norm, out_item.y0 == 32'sd0 && out_item.y1 == 32'sd0 && out_item.y2 == 32'sd0 && out_item.y3 == 32'sd0, "zero norm item with nonzero coordinate")
  `GSNP_ASSERT_IMPL(a_shell_not_zero, vld_r[ISQ_LAT+FRONT_LAT], !(mid_r[0].shell_en && mid_r[0].zn), "shell rescale chosen on zero norm")
  `GSNP_ASSERT_NEXT(a_unused_lane_zero, vld_r[TOTAL_LAT-1] && (DIM < NCOORD), out_item.y3 == 32'sd0, "unused coordinate not zero")

endmodule

// ===== tb/tb_top.sv =====
// testbench for the projected gradient step block: directed and random points checked against a predictor
`timescale 1ns / 1ps

module tb_top;
  import gsnp_pkg::*;

  localparam int DIM_TB = 3;
  localparam int DRAIN_CYCLES = 140;
  localparam int WATCHDOG_LIMIT = 4000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;
  logic      cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  gradient_step_norm_projection_top #(.DIM(DIM_TB)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the configuration
  logic [1:0]  pm_mode;
  logic [31:0] pm_mant;
  logic [5:0]  pm_shift;
  logic [31:0] pm_thresh;
  logic [31:0] pm_radius;

  // expected points and checking
  class proj_scoreboard;
    out_item_t pending[$];
    int errors;
    int checked;

    function void note_point(out_item_t e);
      pending.push_back(e);
    endfunction

    function void check_point(out_item_t got);
      out_item_t e;
      bit bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected point %h", got);
        return;
      end
      e = pending.pop_front();
      checked++;
      bad = (e.index_out !== got.index_out) || (e.y0 !== got.y0) || (e.y1 !== got.y1) ||
            (e.y2 !== got.y2) || (e.y3 !== got.y3) || (e.last_out !== got.last_out) ||
            (e.zero_norm !== got.zero_norm) || (e.saturated !== got.saturated);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch idx exp %h got %h", e.index_out, got.index_out);
          $display("  y exp %h %h %h %h got %h %h %h %h", e.y0, e.y1, e.y2, e.y3,
                   got.y0, got.y1, got.y2, got.y3);
          $display("  last/zn/sat exp %b%b%b got %b%b%b", e.last_out, e.zero_norm,
                   e.saturated, got.last_out, got.zero_norm, got.saturated);
        end
      end
    endfunction
  endclass

  proj_scoreboard sb;

  // clip to q3.28
  function automatic logic signed [31:0] clip_q328(logic signed [127:0] v, ref bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1;
      return POS_MAX;
    end
    if (v < -128'sd2147483648) begin
      sat = 1;
      return NEG_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] rescale_coord(logic signed [31:0] v,
      logic [63:0] num, logic [63:0] den, ref bit sat);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (v < 0) ? 128'(-64'(v)) : 128'(v);
    q = (den != 0) ? (mag * num) / den : 0;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return clip_q328((v < 0) ? -$signed(q) : $signed(q), sat);
  endfunction

  // expected projected point for one input item
  function automatic out_item_t project_point(in_item_t p);
    logic signed [31:0] xs[4];
    logic signed [47:0] gs[4];
    logic signed [31:0] y[4];
    logic [127:0] prod;
    logic [127:0] sq;
    logic [63:0] gm;
    logic [63:0] nrm;
    logic [63:0] r;
    logic signed [127:0] acc;
    logic [63:0] stepm;
    bit sat;
    bit zn;
    out_item_t o;
    xs = '{p.x0, p.x1, p.x2, p.x3};
    gs = '{p.g0, p.g1, p.g2, p.g3};
    y = '{0, 0, 0, 0};
    sat = 0;
    zn = 0;
    nrm = 0;
    for (int j = 0; j < DIM_TB; j++) begin
      gm = (gs[j] < 0) ? 64'(-64'(gs[j])) : 64'(gs[j]);
      prod = 128'(pm_mant) * 128'(gm);
      stepm = 64'(prod >> (28 + pm_shift));
      if (gs[j] < 0) acc = 128'(xs[j]) + $signed(128'(stepm));
      else acc = 128'(xs[j]) - $signed(128'(stepm));
      y[j] = clip_q328(acc, sat);
      sq = 128'(y[j] < 0 ? -64'(y[j]) : 64'(y[j]));
      sq = sq * sq + 128'(nrm);
      nrm = (sq > 128'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : sq[63:0];
    end
    r = int_sqrt(nrm);
    if (pm_mode == MODE_SPHERE) begin
      if (nrm == 0) zn = 1;
      else for (int j = 0; j < DIM_TB; j++) y[j] = rescale_coord(y[j], 64'(UNIT_NUM), r, sat);
    end else begin
      if (nrm > ONE_Q56)
        for (int j = 0; j < DIM_TB; j++) y[j] = rescale_coord(y[j], 64'(UNIT_NUM), r, sat);
      if (pm_mode == MODE_SHELL && nrm < (64'(pm_thresh) << 26)) begin
        if (nrm == 0) zn = 1;
        else for (int j = 0; j < DIM_TB; j++)
          y[j] = rescale_coord(y[j], 64'(pm_radius), r * 4, sat);
      end
    end
    o.index_out = p.point_index;
    o.y0 = y[0];
    o.y1 = y[1];
    o.y2 = y[2];
    o.y3 = y[3];
    o.last_out = p.last_in;
    o.zero_norm = zn;
    o.saturated = sat;
    return o;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // result monitor and watchdog
  int idle_cycles;
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_point(out_item);
    if ((start && !busy) || out_strobe || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // one register write; the caller drops the write enable afterwards
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_MODE:            pm_mode = val[1:0];
      CFG_STEP_MANTISSA:   pm_mant = val;
      CFG_STEP_SHIFT:      pm_shift = val[5:0];
      CFG_INNER_THRESHOLD: pm_thresh = val;
      default:             pm_radius = val;
    endcase
  endtask

  task automatic setup_regs(logic [1:0] md, logic [31:0] mant, logic [5:0] sh,
      logic [31:0] th, logic [31:0] rad);
    write_reg(CFG_MODE, 32'(md));
    write_reg(CFG_STEP_MANTISSA, mant);
    write_reg(CFG_STEP_SHIFT, 32'(sh));
    write_reg(CFG_INNER_THRESHOLD, th);
    write_reg(CFG_SHELL_RADIUS, rad);
    cfg_we <= 0;
  endtask

  // hold start until accepted, then compute the expected point
  task automatic send_point(in_item_t p, bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_item <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_point(project_point(p));
  endtask

  task automatic drain_all();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $signed($urandom());
      1: return POS_MAX;
      2: return NEG_MIN;
      default: return $signed(32'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
    endcase
  endfunction

  function automatic logic signed [47:0] rand_grad();
    case ($urandom_range(0, 4))
      0: return $signed({$urandom(), 16'($urandom())});
      1: return 48'sh7FFF_FFFF_FFFF;
      2: return 48'sh8000_0000_0000;
      default: return 48'($signed(32'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000));
    endcase
  endfunction

  function automatic in_item_t rand_point();
    in_item_t p;
    p.point_index = 20'($urandom());
    p.x0 = rand_coord();
    p.x1 = rand_coord();
    p.x2 = rand_coord();
    p.x3 = rand_coord();
    p.g0 = rand_grad();
    p.g1 = rand_grad();
    p.g2 = rand_grad();
    p.g3 = rand_grad();
    p.last_in = 1'($urandom_range(0, 1));
    return p;
  endfunction

  function automatic in_item_t fixed_point(logic [19:0] idx, logic signed [31:0] a,
      logic signed [31:0] b, logic signed [31:0] c, logic signed [47:0] g, bit lst);
    in_item_t p;
    p = '{point_index: idx, x0: a, x1: b, x2: c, x3: a, g0: g, g1: -g, g2: g, g3: g,
          last_in: lst};
    return p;
  endfunction

  initial begin
    sb = new();
    rst_n = 0;
    start = 0;
    in_item = '0;
    cfg_we = 0;
    cfg_index = CFG_MODE;
    cfg_data = 0;
    pm_mode = MODE_BALL;
    pm_mant = 0;
    pm_shift = 0;
    pm_thresh = 0;
    pm_radius = SHELL_RADIUS_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: zero point, extremes, inside/outside ball in each mode
    for (int m = 0; m < 4; m++) begin
      setup_regs(m[1:0], 32'h8000_0000, 6'd0, 32'h2000_0000, SHELL_RADIUS_RST);
      send_point(fixed_point(20'h0, 0, 0, 0, 0, 0), 0);
      send_point(fixed_point(20'hFFFFF, POS_MAX, NEG_MIN, POS_MAX, 48'sh7FFF_FFFF_FFFF, 1), 0);
      send_point(fixed_point(20'h3, 32'sh0100_0000, 0, 0, 0, 0), 0);
      send_point(fixed_point(20'h4, 32'sh1000_0000, 32'sh1000_0000, 0, 0, 1), 0);
      send_point(fixed_point(20'h5, NEG_MIN, 0, 0, 48'sh8000_0000_0000, 0), 0);
      drain_all();
    end

    // random phases across settings; pauses until all points are back between phases
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: setup_regs(MODE_BALL, 32'h0, 6'd0, 32'h0, 32'h0);
        1: setup_regs(MODE_SHELL, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: setup_regs(MODE_SPHERE, 32'hFFFF_FFFF, 6'd0, 32'h0, SHELL_RADIUS_RST);
        default: setup_regs(2'($urandom_range(0, 3)), $urandom(), 6'($urandom_range(0, 63)),
                            $urandom_range(0, 32'h8000_0000), $urandom());
      endcase
      for (int i = 0; i < 140; i++) send_point(rand_point(), ph < 11);
      drain_all();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/gsnp_pkg.sv
hw/rtl/gsnp_front.sv
hw/rtl/gsnp_isqrt.sv
hw/rtl/gsnp_scale.sv
hw/rtl/gradient_step_norm_projection_top.sv
tb/tb_top.sv
